// ===== rtl/core/nearest_neighbor_image_rotator_top_macros.svh =====
// Assertion macros shared by the rotator RTL.
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATOR_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NNIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NNIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nnir_pkg.sv =====
// Shared constants for the nearest-neighbour image rotator.
package nnir_pkg;

    localparam int DEF_MAX_SIDE   = 64;
    localparam int DEF_PIXEL_BITS = 32;

    localparam int SIDE_REG_W  = 7;
    localparam int COEF_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int Q_BITS     = 14;
    localparam int ROUND_HALF = 1 << (Q_BITS - 1);

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_VALUE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_VALUE    = 2'd3;

    localparam logic [SIDE_REG_W-1:0]    RESET_FRAME_WIDTH  = 7'd64;
    localparam logic [SIDE_REG_W-1:0]    RESET_FRAME_HEIGHT = 7'd64;
    localparam logic signed [COEF_W-1:0] RESET_COS_VALUE    = 16'sd16384;
    localparam logic signed [COEF_W-1:0] RESET_SIN_VALUE    = 16'sd0;

endpackage

// ===== rtl/core/nnir_ram.sv =====
// Generic single-port RAM with registered read.
module nnir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nnir_ctrl.sv =====
// Configuration registers, frame size, and load/emit raster positions.
`include "nearest_neighbor_image_rotator_top_macros.svh"

module nnir_ctrl #(
    parameter int MAX_SIDE = nnir_pkg::DEF_MAX_SIDE
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [nnir_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [nnir_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    take_load,
    input  logic                                    take_emit,
    output logic                                    busy,
    output logic [$clog2(MAX_SIDE+1)-1:0]           width_eff,
    output logic [$clog2(MAX_SIDE+1)-1:0]           height_eff,
    output logic signed [nnir_pkg::COEF_W-1:0]      cos_val,
    output logic signed [nnir_pkg::COEF_W-1:0]      sin_val,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]    load_addr,
    output logic [$clog2(MAX_SIDE)-1:0]             emit_x,
    output logic [$clog2(MAX_SIDE)-1:0]             emit_y,
    output logic                                    emit_last
);

    localparam int SW        = $clog2(MAX_SIDE + 1);
    localparam int CW        = $clog2(MAX_SIDE);
    localparam int AW        = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int TW        = AW + 1;
    localparam int CMPW      = (SW > nnir_pkg::SIDE_REG_W) ? SW : nnir_pkg::SIDE_REG_W;
    localparam int CNT_START = AW + 3;
    localparam int CNT_W     = $clog2(AW + 4);

    function automatic logic [SW-1:0] clamp_side(input logic [nnir_pkg::SIDE_REG_W-1:0] v);
        logic [CMPW-1:0] ve;
        ve = CMPW'(v);
        if (ve == '0)
            clamp_side = SW'(1);
        else if (ve > CMPW'(MAX_SIDE))
            clamp_side = SW'(MAX_SIDE);
        else
            clamp_side = SW'(ve);
    endfunction

    logic [nnir_pkg::SIDE_REG_W-1:0]   fw_reg, fh_reg;
    logic signed [nnir_pkg::COEF_W-1:0] cos_reg, sin_reg;
    logic [SW-1:0]                     w_eff_reg, h_eff_reg;
    logic [TW-1:0]                     total_reg;
    logic                              busy_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [SW-1:0]                     rem_reg;
    logic [AW-1:0]                     quo_reg;
    logic [AW-1:0]                     load_pos_reg, emit_pos_reg;
    logic [CW-1:0]                     x_reg, y_reg;

    logic [SW:0]   trial;
    logic          trial_ge;
    logic [SW-1:0] rem_next;
    logic [AW-1:0] quo_next;
    logic          div_step, div_init, div_done;
    logic          load_wrap, emit_wrap, x_wrap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= nnir_pkg::RESET_FRAME_WIDTH;
            fh_reg  <= nnir_pkg::RESET_FRAME_HEIGHT;
            cos_reg <= nnir_pkg::RESET_COS_VALUE;
            sin_reg <= nnir_pkg::RESET_SIN_VALUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nnir_pkg::REG_FRAME_WIDTH:  fw_reg  <= cfg_data[nnir_pkg::SIDE_REG_W-1:0];
                nnir_pkg::REG_FRAME_HEIGHT: fh_reg  <= cfg_data[nnir_pkg::SIDE_REG_W-1:0];
                nnir_pkg::REG_COS_VALUE:    cos_reg <= signed'(cfg_data[nnir_pkg::COEF_W-1:0]);
                nnir_pkg::REG_SIN_VALUE:    sin_reg <= signed'(cfg_data[nnir_pkg::COEF_W-1:0]);
                default: ;
            endcase
        end
    end

    // size pipeline: clamp, then product; settled well before busy drops
    always_ff @(posedge clk)
    begin
        w_eff_reg <= clamp_side(fw_reg);
        h_eff_reg <= clamp_side(fh_reg);
        total_reg <= TW'(w_eff_reg) * TW'(h_eff_reg);
    end

    // restoring divider: emit position / width gives row and column
    assign div_init = (cnt_reg == CNT_W'(CNT_START));
    assign div_done = (cnt_reg == CNT_W'(2));
    assign div_step = busy_reg && !div_init && (cnt_reg > CNT_W'(2));
    assign trial    = {rem_reg, quo_reg[AW-1]};
    assign trial_ge = (trial >= {1'b0, w_eff_reg});
    assign rem_next = trial_ge ? SW'(trial - {1'b0, w_eff_reg}) : trial[SW-1:0];
    assign quo_next = {quo_reg[AW-2:0], trial_ge};

    assign load_wrap = (TW'(load_pos_reg) + TW'(1)) == total_reg;
    assign emit_wrap = (TW'(emit_pos_reg) + TW'(1)) == total_reg;
    assign x_wrap    = (SW'(x_reg) + SW'(1)) == w_eff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            cnt_reg      <= CNT_W'(CNT_START);
            load_pos_reg <= '0;
            emit_pos_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
        end
        else if (cfg_we)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(CNT_START);
        end
        else if (busy_reg)
        begin
            if (div_done)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
                // a shrunken frame restarts stale positions
                if (TW'(emit_pos_reg) >= total_reg)
                begin
                    emit_pos_reg <= '0;
                    x_reg        <= '0;
                    y_reg        <= '0;
                end
                else
                begin
                    x_reg <= rem_reg[CW-1:0];
                    y_reg <= quo_reg[CW-1:0];
                end
                if (TW'(load_pos_reg) >= total_reg)
                begin
                    load_pos_reg <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
        else
        begin
            if (take_load)
            begin
                load_pos_reg <= load_wrap ? '0 : load_pos_reg + AW'(1);
            end
            if (take_emit)
            begin
                if (emit_wrap)
                begin
                    emit_pos_reg <= '0;
                    x_reg        <= '0;
                    y_reg        <= '0;
                end
                else
                begin
                    emit_pos_reg <= emit_pos_reg + AW'(1);
                    if (x_wrap)
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + CW'(1);
                    end
                    else
                    begin
                        x_reg <= x_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_init)
        begin
            rem_reg <= '0;
            quo_reg <= emit_pos_reg;
        end
        else if (div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy       = busy_reg;
    assign width_eff  = w_eff_reg;
    assign height_eff = h_eff_reg;
    assign cos_val    = cos_reg;
    assign sin_val    = sin_reg;
    assign load_addr  = load_pos_reg;
    assign emit_x     = x_reg;
    assign emit_y     = y_reg;
    assign emit_last  = emit_wrap;

    `NNIR_ASSERT_NOW(a_load_in_frame, !busy_reg, TW'(load_pos_reg) < total_reg, "load position beyond frame")
    `NNIR_ASSERT_NOW(a_emit_in_frame, !busy_reg, TW'(emit_pos_reg) < total_reg, "emit position beyond frame")
    `NNIR_ASSERT_NOW(a_col_in_row, !busy_reg, SW'(x_reg) < w_eff_reg, "emit column beyond width")

endmodule

// ===== rtl/core/nnir_rot.sv =====
// Rotation datapath: source coordinate, rounding, bounds and store address.
module nnir_rot #(
    parameter int MAX_SIDE   = nnir_pkg::DEF_MAX_SIDE,
    parameter int PIXEL_BITS = nnir_pkg::DEF_PIXEL_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  take,
    input  logic                                  mode,
    input  logic [PIXEL_BITS-1:0]                 pixel,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  load_addr,
    input  logic [$clog2(MAX_SIDE)-1:0]           emit_x,
    input  logic [$clog2(MAX_SIDE)-1:0]           emit_y,
    input  logic                                  emit_last,
    input  logic [$clog2(MAX_SIDE+1)-1:0]         width_eff,
    input  logic [$clog2(MAX_SIDE+1)-1:0]         height_eff,
    input  logic signed [nnir_pkg::COEF_W-1:0]    cos_val,
    input  logic signed [nnir_pkg::COEF_W-1:0]    sin_val,
    output logic                                  mem_valid,
    output logic                                  mem_emit,
    output logic                                  mem_inside,
    output logic                                  mem_last,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  mem_addr,
    output logic [PIXEL_BITS-1:0]                 mem_wdata
);

    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int CW   = $clog2(MAX_SIDE);
    localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int DW   = SW + 1;
    localparam int PW   = DW + nnir_pkg::COEF_W;
    localparam int SUMW = PW + 2;
    localparam int RW   = SUMW - nnir_pkg::Q_BITS;
    localparam int MW   = CW + SW;

    // stage 1: captured item
    logic                  v1_reg, m1_reg, l1_reg;
    logic [PIXEL_BITS-1:0] pix1_reg;
    logic [AW-1:0]         la1_reg;
    logic [CW-1:0]         x1_reg, y1_reg;
    // stage 2: products
    logic                  v2_reg, m2_reg, l2_reg;
    logic [PIXEL_BITS-1:0] pix2_reg;
    logic [AW-1:0]         la2_reg;
    logic signed [PW-1:0]  dxc_reg, dys_reg, dyc_reg, dxs_reg;
    // stage 3: Q.14 source coordinates
    logic                  v3_reg, m3_reg, l3_reg;
    logic [PIXEL_BITS-1:0] pix3_reg;
    logic [AW-1:0]         la3_reg;
    logic signed [SUMW-1:0] sx3_reg, sy3_reg;
    // stage 4: integer source coordinates
    logic                  v4_reg, m4_reg, l4_reg, in4_reg;
    logic [PIXEL_BITS-1:0] pix4_reg;
    logic [AW-1:0]         la4_reg;
    logic [CW-1:0]         sx4_reg, sy4_reg;
    // stage 5: store access
    logic                  v5_reg, m5_reg, l5_reg, in5_reg;
    logic [PIXEL_BITS-1:0] pix5_reg;
    logic [AW-1:0]         a5_reg;

    logic [SW-1:0]          cx, cy;
    logic signed [DW-1:0]   dx, dy;
    logic signed [PW-1:0]   dxc_next, dys_next, dyc_next, dxs_next;
    logic signed [SUMW-1:0] cxq, cyq, sx_next, sy_next;
    logic [SUMW-1:0]        rxf, ryf;
    logic signed [RW-1:0]   rx, ry;
    logic                   inside_next;
    logic [AW-1:0]          addr_next;

    assign cx = width_eff >> 1;
    assign cy = height_eff >> 1;

    assign dx = signed'(DW'(x1_reg)) - signed'(DW'(cx));
    assign dy = signed'(DW'(y1_reg)) - signed'(DW'(cy));
    assign dxc_next = PW'(dx) * PW'(cos_val);
    assign dys_next = PW'(dy) * PW'(sin_val);
    assign dyc_next = PW'(dy) * PW'(cos_val);
    assign dxs_next = PW'(dx) * PW'(sin_val);

    assign cxq     = signed'(SUMW'(cx)) <<< nnir_pkg::Q_BITS;
    assign cyq     = signed'(SUMW'(cy)) <<< nnir_pkg::Q_BITS;
    assign sx_next = SUMW'(dxc_reg) + SUMW'(dys_reg) + cxq;
    assign sy_next = SUMW'(dyc_reg) - SUMW'(dxs_reg) + cyq;

    // half away from zero: negative values take one less than the half
    assign rxf = sx3_reg + SUMW'(nnir_pkg::ROUND_HALF) - SUMW'(sx3_reg[SUMW-1]);
    assign ryf = sy3_reg + SUMW'(nnir_pkg::ROUND_HALF) - SUMW'(sy3_reg[SUMW-1]);
    assign rx  = rxf[SUMW-1:nnir_pkg::Q_BITS];
    assign ry  = ryf[SUMW-1:nnir_pkg::Q_BITS];
    assign inside_next = !rx[RW-1] && (rx < signed'(RW'(width_eff)))
                      && !ry[RW-1] && (ry < signed'(RW'(height_eff)));

    assign addr_next = AW'(MW'(sy4_reg) * MW'(width_eff) + MW'(sx4_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= mode;
            l1_reg   <= emit_last;
            pix1_reg <= pixel;
            la1_reg  <= load_addr;
            x1_reg   <= emit_x;
            y1_reg   <= emit_y;

            m2_reg   <= m1_reg;
            l2_reg   <= l1_reg;
            pix2_reg <= pix1_reg;
            la2_reg  <= la1_reg;
            dxc_reg  <= dxc_next;
            dys_reg  <= dys_next;
            dyc_reg  <= dyc_next;
            dxs_reg  <= dxs_next;

            m3_reg   <= m2_reg;
            l3_reg   <= l2_reg;
            pix3_reg <= pix2_reg;
            la3_reg  <= la2_reg;
            sx3_reg  <= sx_next;
            sy3_reg  <= sy_next;

            m4_reg   <= m3_reg;
            l4_reg   <= l3_reg;
            pix4_reg <= pix3_reg;
            la4_reg  <= la3_reg;
            in4_reg  <= inside_next;
            sx4_reg  <= rx[CW-1:0];
            sy4_reg  <= ry[CW-1:0];

            m5_reg   <= m4_reg;
            l5_reg   <= l4_reg;
            pix5_reg <= pix4_reg;
            in5_reg  <= in4_reg;
            a5_reg   <= m4_reg ? addr_next : la4_reg;
        end
    end

    assign mem_valid  = v5_reg;
    assign mem_emit   = m5_reg;
    assign mem_inside = in5_reg;
    assign mem_last   = l5_reg;
    assign mem_addr   = a5_reg;
    assign mem_wdata  = pix5_reg;

endmodule

// ===== rtl/core/nearest_neighbor_image_rotator_top.sv =====
// Nearest-neighbour image rotator: top level.
//
// Input channel (in_valid/in_stall, mode, pixel_in): mode 0 loads pixel_in
// into the frame store at the next raster position; mode 1 asks for the next
// rotated pixel in raster order. Output channel (out_valid/out_stall,
// pixel_out, frame_end) returns one transaction per emit and none per load;
// frame_end marks the last pixel of the frame. Emits make sense only once a
// whole frame has been loaded.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle (not enforced by the block).
// Throughput: one transaction per cycle while in_stall is low, loads and emits freely mixed.
// An accepted emit passes the datapath stages (captured item, products, Q.14
// source coordinates, integer source coordinates, store access), then the store
// read register, which is also the output register.
// After reset and after every configuration write, in_stall is high while a
// bit-serial divider turns the emit position back into a column and row.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised.
`include "nearest_neighbor_image_rotator_top_macros.svh"

module nearest_neighbor_image_rotator_top #(
    parameter int MAX_SIDE   = nnir_pkg::DEF_MAX_SIDE,
    parameter int PIXEL_BITS = nnir_pkg::DEF_PIXEL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nnir_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [nnir_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [PIXEL_BITS-1:0]             pixel_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [PIXEL_BITS-1:0]             pixel_out,
    output logic                              frame_end
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    logic                        busy, en, take;
    logic [SW-1:0]               width_eff, height_eff;
    logic signed [nnir_pkg::COEF_W-1:0] cos_val, sin_val;
    logic [AW-1:0]               load_addr, mem_addr;
    logic [CW-1:0]               emit_x, emit_y;
    logic                        emit_last;
    logic                        mem_valid, mem_emit, mem_inside, mem_last;
    logic [PIXEL_BITS-1:0]       mem_wdata, mem_rdata;
    logic                        out_valid_reg, out_inside_reg, out_last_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = busy || !en;
    assign take     = in_valid && !in_stall;

    nnir_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take_load  (take && !mode),
        .take_emit  (take && mode),
        .busy       (busy),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .cos_val    (cos_val),
        .sin_val    (sin_val),
        .load_addr  (load_addr),
        .emit_x     (emit_x),
        .emit_y     (emit_y),
        .emit_last  (emit_last)
    );

    nnir_rot #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_rot (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (take),
        .mode       (mode),
        .pixel      (pixel_in),
        .load_addr  (load_addr),
        .emit_x     (emit_x),
        .emit_y     (emit_y),
        .emit_last  (emit_last),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .cos_val    (cos_val),
        .sin_val    (sin_val),
        .mem_valid  (mem_valid),
        .mem_emit   (mem_emit),
        .mem_inside (mem_inside),
        .mem_last   (mem_last),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata)
    );

    // loads write and emits read at the same stage, so order is kept
    nnir_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (en),
        .we    (mem_valid && !mem_emit),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mem_valid && mem_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_inside_reg <= mem_inside;
            out_last_reg   <= mem_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = out_inside_reg ? mem_rdata : '0;
    assign frame_end = out_last_reg;

    `NNIR_ASSERT_NOW(a_hold_on_stall, out_valid && out_stall, in_stall, "input taken while output blocked")
    `NNIR_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, in_stall, "input not blocked after configuration write")

endmodule

// ===== bench/tb_nearest_neighbor_image_rotator_top.sv =====
// Self-checking testbench for the nearest-neighbour image rotator.
module tb_nearest_neighbor_image_rotator_top;

    localparam int STORE_WORDS   = nnir_pkg::DEF_MAX_SIDE * nnir_pkg::DEF_MAX_SIDE;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 340;
    localparam int LONG_HOLD     = 80;

    typedef enum logic {OP_LOAD = 1'b0, OP_EMIT = 1'b1} op_t;

    typedef struct packed {
        logic [nnir_pkg::DEF_PIXEL_BITS-1:0] pixel;
        logic                                last;
    } rotated_pixel_t;

    class rotation_scoreboard;
        logic [nnir_pkg::DEF_PIXEL_BITS-1:0] frame_words [STORE_WORDS];
        logic [nnir_pkg::SIDE_REG_W-1:0]     width_reg;
        logic [nnir_pkg::SIDE_REG_W-1:0]     height_reg;
        logic signed [nnir_pkg::COEF_W-1:0]  cos_reg;
        logic signed [nnir_pkg::COEF_W-1:0]  sin_reg;
        int                                  load_pos;
        int                                  emit_pos;
        rotated_pixel_t                      awaited_pixels [$];
        int                                  errors;

        function new();
            foreach (frame_words[i])
                frame_words[i] = '0;
            width_reg  = nnir_pkg::RESET_FRAME_WIDTH;
            height_reg = nnir_pkg::RESET_FRAME_HEIGHT;
            cos_reg    = nnir_pkg::RESET_COS_VALUE;
            sin_reg    = nnir_pkg::RESET_SIN_VALUE;
            load_pos   = 0;
            emit_pos   = 0;
            errors     = 0;
        endfunction

        // Out-of-range sides are clamped to 1..MAX_SIDE
        function int used_side(logic [nnir_pkg::SIDE_REG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > nnir_pkg::DEF_MAX_SIDE)
                return nnir_pkg::DEF_MAX_SIDE;
            return int'(v);
        endfunction

        function int frame_total();
            return used_side(width_reg) * used_side(height_reg);
        endfunction

        function void write_reg(logic [nnir_pkg::CFG_INDEX_W-1:0] idx,
                                logic [nnir_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nnir_pkg::REG_FRAME_WIDTH:  width_reg  = data[nnir_pkg::SIDE_REG_W-1:0];
                nnir_pkg::REG_FRAME_HEIGHT: height_reg = data[nnir_pkg::SIDE_REG_W-1:0];
                nnir_pkg::REG_COS_VALUE:    cos_reg    = data;
                nnir_pkg::REG_SIN_VALUE:    sin_reg    = data;
                default: ;
            endcase
        endfunction

        // Q.14 to integer, ties away from zero
        function longint round_half_away(longint v);
            longint mag;
            longint r;
            mag = (v < 0) ? -v : v;
            r = (mag + nnir_pkg::ROUND_HALF) >>> nnir_pkg::Q_BITS;
            return (v < 0) ? -r : r;
        endfunction

        function void apply_item(op_t op, logic [nnir_pkg::DEF_PIXEL_BITS-1:0] word);
            int             w;
            int             h;
            int             total;
            int             p;
            longint         cx;
            longint         cy;
            longint         dx;
            longint         dy;
            longint         sx;
            longint         sy;
            rotated_pixel_t r;
            w = used_side(width_reg);
            h = used_side(height_reg);
            total = w * h;
            if (op == OP_LOAD)
            begin
                if (load_pos >= total)
                    load_pos = 0;
                frame_words[load_pos] = word;
                load_pos++;
                if (load_pos >= total)
                    load_pos = 0;
                return;
            end
            if (emit_pos >= total)
                emit_pos = 0;
            p  = emit_pos;
            cx = w / 2;
            cy = h / 2;
            dx = longint'(p % w) - cx;
            dy = longint'(p / w) - cy;
            sx = round_half_away(dx * longint'(cos_reg) + dy * longint'(sin_reg)
                                 + (cx <<< nnir_pkg::Q_BITS));
            sy = round_half_away(dy * longint'(cos_reg) - dx * longint'(sin_reg)
                                 + (cy <<< nnir_pkg::Q_BITS));
            r.pixel = '0;
            if (sx >= 0 && sx < longint'(w) && sy >= 0 && sy < longint'(h))
                r.pixel = frame_words[sy * w + sx];
            r.last = (p == total - 1);
            awaited_pixels.push_back(r);
            emit_pos = p + 1;
            if (emit_pos >= total)
                emit_pos = 0;
        endfunction

        function void compare_pixel(logic [nnir_pkg::DEF_PIXEL_BITS-1:0] pixel, logic last);
            rotated_pixel_t e;
            if (awaited_pixels.size() == 0)
            begin
                $display("%0t: result with nothing awaited: pixel_out %h frame_end %b",
                         $time, pixel, last);
                errors++;
                return;
            end
            e = awaited_pixels.pop_front();
            if (pixel !== e.pixel)
            begin
                $display("%0t: pixel_out expected %h actual %h", $time, e.pixel, pixel);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: frame_end expected %b actual %b", $time, e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [nnir_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [nnir_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic                                mode;
    logic [nnir_pkg::DEF_PIXEL_BITS-1:0] pixel_in;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [nnir_pkg::DEF_PIXEL_BITS-1:0] pixel_out;
    logic                                frame_end;

    rotation_scoreboard sb = new();

    int          covered_total   = 0;
    int          loads_since_cfg = 0;
    int          random_items    = 0;
    int          burst_left      = 0;
    bit          steady          = 1'b1;
    int          hold_request    = 0;
    int unsigned cycle_count     = 0;

    logic [nnir_pkg::DEF_PIXEL_BITS-1:0] corner_words [9] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000,
        32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF
    };
    logic [nnir_pkg::COEF_W-1:0] extreme_coefs [4] = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000};

    nearest_neighbor_image_rotator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.apply_item(op_t'(mode), pixel_in);
            if (out_valid && !out_stall)
                sb.compare_pixel(pixel_out, frame_end);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_nearest_neighbor_image_rotator_top: done, errors");
        $finish;
    end

    // Receiver: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int pattern_left;
        int stall_pct;
        hold_left    = 0;
        pattern_left = 0;
        stall_pct    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 25;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic bit can_emit();
        return covered_total >= sb.frame_total();
    endfunction

    function automatic logic [nnir_pkg::SIDE_REG_W-1:0] pick_side();
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 7'd0;
                1: return 7'd1;
                2: return 7'd64;
                default: return 7'($urandom_range(65, 127));
            endcase
        end
        return 7'($urandom_range(1, 8));
    endfunction

    // All tasks are entered and left at a falling edge
    task automatic send_item(input op_t op, input logic [nnir_pkg::DEF_PIXEL_BITS-1:0] word);
        in_valid <= 1'b1;
        mode     <= op;
        pixel_in <= word;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (op == OP_LOAD)
        begin
            loads_since_cfg++;
            // a run of total loads from any position fills the whole frame
            if (loads_since_cfg >= sb.frame_total() && covered_total < sb.frame_total())
                covered_total = sb.frame_total();
        end
    endtask

    task automatic paced_send(input op_t op, input logic [nnir_pkg::DEF_PIXEL_BITS-1:0] word);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        send_item(op, word);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_one(input logic [nnir_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [nnir_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_frame(input logic [nnir_pkg::SIDE_REG_W-1:0] w,
                                 input logic [nnir_pkg::SIDE_REG_W-1:0] h,
                                 input logic [nnir_pkg::COEF_W-1:0] c,
                                 input logic [nnir_pkg::COEF_W-1:0] s);
        write_one(nnir_pkg::REG_FRAME_WIDTH, nnir_pkg::CFG_DATA_W'(w));
        write_one(nnir_pkg::REG_FRAME_HEIGHT, nnir_pkg::CFG_DATA_W'(h));
        write_one(nnir_pkg::REG_COS_VALUE, c);
        write_one(nnir_pkg::REG_SIN_VALUE, s);
        cfg_we <= 1'b0;
        loads_since_cfg = 0;
    endtask

    task automatic run_phase(input int phase_no);
        logic [nnir_pkg::COEF_W-1:0]     c_val;
        logic [nnir_pkg::COEF_W-1:0]     s_val;
        logic [nnir_pkg::SIDE_REG_W-1:0] w_pick;
        logic [nnir_pkg::SIDE_REG_W-1:0] h_pick;
        int                              len;
        int                              emit_pct;
        int                              angle;
        real                             rad;
        bit                              hold_done;
        op_t                             op;
        wait_idle();
        case ($urandom_range(0, 4))
            0:
            begin
                angle = $urandom_range(0, 359);
                rad   = angle * 3.14159265358979 / 180.0;
                c_val = 16'($rtoi($floor(16384.0 * $cos(rad) + 0.5)));
                s_val = 16'($rtoi($floor(16384.0 * $sin(rad) + 0.5)));
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0: begin c_val = 16'd16384;  s_val = 16'd0;      end
                    1: begin c_val = 16'd0;      s_val = 16'd16384;  end
                    2: begin c_val = -16'd16384; s_val = 16'd0;      end
                    default: begin c_val = 16'd0; s_val = -16'd16384; end
                endcase
            end
            2:
            begin
                c_val = 16'($urandom);
                s_val = 16'($urandom);
            end
            3:
            begin
                c_val = 16'($urandom_range(0, 32768) - 16384);
                s_val = 16'($urandom_range(0, 32768) - 16384);
            end
            default:
            begin
                c_val = extreme_coefs[$urandom_range(0, 3)];
                s_val = extreme_coefs[$urandom_range(0, 3)];
            end
        endcase
        w_pick = pick_side();
        h_pick = pick_side();
        // hold-off phase keeps a small frame so that emits start soon
        if (phase_no == 2)
        begin
            w_pick = 7'($urandom_range(1, 8));
            h_pick = 7'($urandom_range(1, 8));
        end
        program_frame(w_pick, h_pick, c_val, s_val);
        steady    = ($urandom_range(0, 3) == 0);
        emit_pct  = $urandom_range(20, 80);
        len       = $urandom_range(20, 80);
        hold_done = 1'b0;
        if (phase_no == 2)
            len = sb.frame_total() + 60;
        for (int n = 0; n < len; n++)
        begin
            // once emits can flow, block the receiver and keep offering emits
            if (phase_no == 2 && !hold_done && can_emit())
            begin
                hold_request = LONG_HOLD;
                hold_done    = 1'b1;
                steady       = 1'b1;
                emit_pct     = 90;
            end
            if (phase_no == 4 && n == len / 2)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            op = (can_emit() && $urandom_range(0, 99) < emit_pct) ? OP_EMIT : OP_LOAD;
            paced_send(op, $urandom);
            random_items++;
        end
    endtask

    initial
    begin
        int phase_no;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = OP_LOAD;
        pixel_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = nnir_pkg::REG_FRAME_WIDTH;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        wait_idle();

        // 3x3 frame turned a quarter: corner words, full frame out, then stop mid-frame
        steady = 1'b1;
        program_frame(7'd3, 7'd3, 16'd0, 16'd16384);
        foreach (corner_words[i])
            send_item(OP_LOAD, corner_words[i]);
        repeat (9) send_item(OP_EMIT, $urandom);
        repeat (2) send_item(OP_LOAD, $urandom);
        repeat (4) send_item(OP_EMIT, $urandom);

        // zero width, shrink past both positions, most negative / positive coefficients
        wait_idle();
        program_frame(7'd0, 7'd2, 16'h8000, 16'h7FFF);
        repeat (3) send_item(OP_EMIT, $urandom);
        send_item(OP_LOAD, $urandom);
        send_item(OP_EMIT, $urandom);

        // full-width frame two rows high, width register above range,
        // 30 degrees (exact ties on sine)
        wait_idle();
        steady = 1'b0;
        program_frame(7'd127, 7'd2, 16'd14189, 16'd8192);
        repeat (2 * nnir_pkg::DEF_MAX_SIDE) paced_send(OP_LOAD, $urandom);
        repeat (2 * nnir_pkg::DEF_MAX_SIDE) paced_send(OP_EMIT, $urandom);

        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("tb_nearest_neighbor_image_rotator_top: done, clean");
        else
            $display("tb_nearest_neighbor_image_rotator_top: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/nnir_pkg.sv
rtl/core/nnir_ram.sv
rtl/core/nnir_ctrl.sv
rtl/core/nnir_rot.sv
rtl/core/nearest_neighbor_image_rotator_top.sv
bench/tb_nearest_neighbor_image_rotator_top.sv
